// ----- rtl/hgcd_pkg.sv -----
package hgcd_pkg;

  localparam int unsigned RadiusW = 26;
  localparam int unsigned LatW    = 31;
  localparam int unsigned LonW    = 32;
  localparam int unsigned DistW   = 28;

  localparam logic [RadiusW-1:0] RadiusReset = 26'd6371000;
  localparam int unsigned CordicStagesDefault = 32;

  localparam longint HalfTurn = 64'sd1440000000;
  localparam longint FullTurn = 64'sd2880000000;
  // round(pi * 2^61 / 2880000000)
  localparam logic [63:0] Krad = (64'h6487ED5110B4611A + 64'd1440000000) / 64'd2880000000;
  localparam logic signed [35:0] CordicX0 = 36'sh026DD3B6A;
  localparam logic signed [35:0] OneQ30   = 36'sh040000000;
  localparam logic [32:0] PiQ30 = 33'd3373259426;

  // arc tangent of 2^-i in Q30
  function automatic logic signed [35:0] atan_q30(input int unsigned i);
    logic signed [35:0] r;
    begin
      unique case (i)
        0: r = 36'sh03243F6A8;
        1: r = 36'sh01DAC6705;
        2: r = 36'sh00FADBAFC;
        3: r = 36'sh007F56EA6;
        4: r = 36'sh003FEAB76;
        5: r = 36'sh001FFD55B;
        6: r = 36'sh000FFFAAA;
        7: r = 36'sh0007FFF55;
        8: r = 36'sd4194282;
        9: r = 36'sd2097149;
        default: r = (i <= 30) ? (36'sd1 <<< (30 - i)) - 36'sd1 : 36'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- rtl/hgcd_if.sv -----
interface hgcd_in_if;
  logic valid;
  logic ready;
  logic signed [hgcd_pkg::LatW-1:0] first_latitude;
  logic signed [hgcd_pkg::LonW-1:0] first_longitude;
  logic signed [hgcd_pkg::LatW-1:0] second_latitude;
  logic signed [hgcd_pkg::LonW-1:0] second_longitude;
  modport source (output valid, first_latitude, first_longitude, second_latitude,
                  second_longitude, input ready);
  modport sink (input valid, first_latitude, first_longitude, second_latitude,
                second_longitude, output ready);
endinterface

interface hgcd_out_if;
  logic valid;
  logic ready;
  logic [hgcd_pkg::DistW-1:0] distance_metres;
  modport source (output valid, distance_metres, input ready);
  modport sink (input valid, distance_metres, output ready);
endinterface

// ----- rtl/haversine_great_circle_distance.sv -----
// Haversine great-circle distance, fully pipelined.
// in_ch  : a transaction carries two positions (lat/lon, 1/8 microdegree, signed).
// out_ch : a transaction carries distance_metres, rounded to the nearest metre.
// cfg_we/cfg_wdata : writes earth_radius (metres, 26 bits); write only while idle.
// One transaction is accepted every cycle unless out_ch stalls. The stages are:
// three input stages (wrap, radian scale, round), the rotation CORDIC for sin/cos
// (CORDIC_STAGES), five product stages, two 32-stage square root pipelines side by
// side, the vectoring CORDIC for atan2 (CORDIC_STAGES), then the angle clamp and the
// radius product.
// The whole pipeline advances only when its last stage is empty or being taken, so
// a stall on out_ch freezes every stage and drops nothing; in_ch.ready follows.
// Reset (rst_n low, synchronous) clears all valid bits and loads earth_radius with
// 6371000 metres.
module haversine_great_circle_distance #(
  parameter int unsigned CORDIC_STAGES = hgcd_pkg::CordicStagesDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  hgcd_in_if.sink                      in_ch,
  hgcd_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [hgcd_pkg::RadiusW-1:0] cfg_wdata
);

  localparam int unsigned NS = CORDIC_STAGES;
  localparam int unsigned SQ = 16;            // half the stage count of each square root pipeline
  localparam int unsigned NSTG = 4 + NS + 4 + 2 * SQ + NS + 2;

  typedef logic signed [35:0] cv_t;

  logic [hgcd_pkg::RadiusW-1:0] radius_r;
  logic adv;
  logic [NSTG-1:0] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) radius_r <= hgcd_pkg::RadiusReset;
    else if (cfg_we) radius_r <= cfg_wdata;
  end

  assign adv = !v_r[NSTG-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NSTG-2:0], in_ch.valid};
  end

  // ---------- stage A: differences and wrap to one turn ----------
  function automatic logic signed [33:0] wrap(input logic signed [33:0] d);
    logic signed [33:0] m;
    begin
      m = d;
      if (m >= 34'(hgcd_pkg::HalfTurn)) m = m - 34'(hgcd_pkg::FullTurn);
      else if (m < -34'(hgcd_pkg::HalfTurn)) m = m + 34'(hgcd_pkg::FullTurn);
      if (m >= 34'(hgcd_pkg::HalfTurn)) m = m - 34'(hgcd_pkg::FullTurn);
      else if (m < -34'(hgcd_pkg::HalfTurn)) m = m + 34'(hgcd_pkg::FullTurn);
      return m;
    end
  endfunction

  logic signed [33:0] ang_r [4];   // dlat, dlon, lat1, lat2
  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r[0] <= wrap(34'(in_ch.second_latitude) - 34'(in_ch.first_latitude));
      ang_r[1] <= wrap(34'(in_ch.second_longitude) - 34'(in_ch.first_longitude));
      ang_r[2] <= wrap(34'(in_ch.first_latitude));
      ang_r[3] <= wrap(34'(in_ch.second_latitude));
    end
  end

  // ---------- stage B: magnitude times Krad ----------
  logic [63:0] prod_r [4];
  logic        neg_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        prod_r[k] <= 64'(ang_r[k] < 0 ? -ang_r[k] : ang_r[k]) * hgcd_pkg::Krad;
        neg_r[k] <= ang_r[k] < 0;
      end
    end
  end

  // ---------- stage C: round and sign -> z (Q2.30) ----------
  cv_t zc_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        zc_r[k] <= neg_r[k] ? -cv_t'((prod_r[k] + 64'h80000000) >> 32) * 2
                            :  cv_t'((prod_r[k] + 64'h80000000) >> 32) * 2;
      end
    end
  end

  // stage D is the rotation CORDIC, NS stages, four lanes
  cv_t rx_r [NS+1][4];
  cv_t ry_r [NS+1][4];
  cv_t rz_r [NS+1][4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rx_r[0][k] = hgcd_pkg::CordicX0;
      ry_r[0][k] = '0;
      rz_r[0][k] = zc_r[k];
    end
  end
  for (genvar i = 0; i < NS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int k = 0; k < 4; k++) begin
          if (rz_r[i][k] >= 0) begin
            rx_r[i+1][k] <= rx_r[i][k] - (ry_r[i][k] >>> i);
            ry_r[i+1][k] <= ry_r[i][k] + (rx_r[i][k] >>> i);
            rz_r[i+1][k] <= rz_r[i][k] - hgcd_pkg::atan_q30(i);
          end else begin
            rx_r[i+1][k] <= rx_r[i][k] + (ry_r[i][k] >>> i);
            ry_r[i+1][k] <= ry_r[i][k] - (rx_r[i][k] >>> i);
            rz_r[i+1][k] <= rz_r[i][k] + hgcd_pkg::atan_q30(i);
          end
        end
      end
    end
  end

  function automatic logic signed [31:0] clampu(input cv_t v);
    if (v > hgcd_pkg::OneQ30) return 32'(hgcd_pkg::OneQ30);
    if (v < -hgcd_pkg::OneQ30) return -32'(hgcd_pkg::OneQ30);
    return 32'(v);
  endfunction

  // E1: squares
  logic signed [63:0] sd2_r, sl2_r, c1c_r, c1s_r, c2c_r, c2s_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sd2_r <= 64'(clampu(ry_r[NS][0])) * 64'(clampu(ry_r[NS][0]));
      sl2_r <= 64'(clampu(ry_r[NS][1])) * 64'(clampu(ry_r[NS][1]));
      c1c_r <= 64'(clampu(rx_r[NS][2])) * 64'(clampu(rx_r[NS][2]));
      c1s_r <= 64'(clampu(ry_r[NS][2])) * 64'(clampu(ry_r[NS][2]));
      c2c_r <= 64'(clampu(rx_r[NS][3])) * 64'(clampu(rx_r[NS][3]));
      c2s_r <= 64'(clampu(ry_r[NS][3])) * 64'(clampu(ry_r[NS][3]));
    end
  end

  // E2: t1, q, cos(lat1), cos(lat2)
  logic signed [35:0] t1_r, q_r, cl1_r, cl2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r  <= 36'((sd2_r + 64'sd134217728) >>> 28);
      q_r   <= 36'((sl2_r + 64'sd536870912) >>> 30);
      cl1_r <= 36'((c1c_r - c1s_r + 64'sd536870912) >>> 30);
      cl2_r <= 36'((c2c_r - c2s_r + 64'sd536870912) >>> 30);
    end
  end

  // E3: cc product; E4: cc rounded, t1 delayed
  logic signed [71:0] ccp_r;
  logic signed [35:0] t1d_r [3];
  logic signed [35:0] qd_r [2];
  logic signed [35:0] cc_r;
  logic signed [71:0] t2p_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ccp_r <= 72'(cl1_r) * 72'(cl2_r);
      t1d_r[0] <= t1_r;
      qd_r[0] <= q_r;
      cc_r <= 36'((ccp_r + 72'sd536870912) >>> 30);
      t1d_r[1] <= t1d_r[0];
      qd_r[1] <= qd_r[0];
      t2p_r <= 72'(cc_r) * 72'(qd_r[1]);
      t1d_r[2] <= t1d_r[1];
    end
  end

  // saturate a to Q0.32
  logic signed [37:0] asum;
  logic [31:0] a_val;
  always_comb begin
    asum = 38'(t1d_r[2]) + 38'((t2p_r + 72'sd134217728) >>> 28);
    if (asum < 0) a_val = '0;
    else if (asum > 38'sh0FFFFFFFF) a_val = '1;
    else a_val = asum[31:0];
  end

  // square roots of a*2^28 and (2^32-a)*2^28: one result bit per stage.
  // Operand width 62 bits -> 31 result bits; two bits of radicand per stage.
  localparam int unsigned RB = 31;
  typedef struct packed {
    logic [61:0] rem;
    logic [61:0] res;
    logic [61:0] bit_v;
  } sq_t;

  sq_t sy_r [2*SQ+1];
  sq_t sx_r [2*SQ+1];
  always_comb begin
    sy_r[0].rem   = {a_val, 28'd0, 2'd0} >> 2;
    sy_r[0].res   = '0;
    sy_r[0].bit_v = 62'd1 << (2 * (RB - 1));
    sx_r[0].rem   = 62'({1'b0, 33'h100000000 - 33'(a_val)} << 28);
    sx_r[0].res   = '0;
    sx_r[0].bit_v = 62'd1 << (2 * (RB - 1));
  end

  function automatic sq_t sq_step(input sq_t s);
    sq_t o;
    begin
      o = s;
      if (s.bit_v != 0) begin
        if (s.rem >= s.res + s.bit_v) begin
          o.rem = s.rem - (s.res + s.bit_v);
          o.res = (s.res >> 1) + s.bit_v;
        end else begin
          o.res = s.res >> 1;
        end
        o.bit_v = s.bit_v >> 2;
      end
      return o;
    end
  endfunction

  for (genvar j = 0; j < 2 * SQ; j++) begin : g_sq
    always_ff @(posedge clk) begin
      if (adv) begin
        sy_r[j+1] <= sq_step(sy_r[j]);
        sx_r[j+1] <= sq_step(sx_r[j]);
      end
    end
  end

  // vectoring CORDIC
  cv_t vx_r [NS+1];
  cv_t vy_r [NS+1];
  cv_t vz_r [NS+1];
  always_comb begin
    vx_r[0] = cv_t'(sx_r[2*SQ].res);
    vy_r[0] = cv_t'(sy_r[2*SQ].res);
    vz_r[0] = '0;
  end
  for (genvar i = 0; i < NS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (adv) begin
        if (vy_r[i] >= 0) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + hgcd_pkg::atan_q30(i);
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - hgcd_pkg::atan_q30(i);
        end
      end
    end
  end

  // clamp angle, then radius product, then round
  logic [32:0] cang_r;
  logic [58:0] dprod_r;
  cv_t ang2;
  assign ang2 = vz_r[NS] <<< 1;
  always_ff @(posedge clk) begin
    if (adv) begin
      if (ang2 < 0) cang_r <= '0;
      else if (ang2 > cv_t'(hgcd_pkg::PiQ30)) cang_r <= hgcd_pkg::PiQ30;
      else cang_r <= ang2[32:0];
      dprod_r <= 59'(radius_r) * 59'(cang_r);
    end
  end

  assign out_ch.valid = v_r[NSTG-1];
  assign out_ch.distance_metres = hgcd_pkg::DistW'((dprod_r + 59'(1 << 29)) >> 30);

endmodule
